[sv/fnmb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fnmb_pkg
// Shared types, widths and constants of the cross mean filter.
// ----------------------------------------------------------------------------
package fnmb_pkg;

  localparam int PIX_W        = 8;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_W     = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;
  localparam int SUM_W        = 11;   // five 8-bit terms
  localparam int DIV_W        = 3;    // divisor 1..5
  localparam int RECIP_W      = 14;
  localparam int RECIP_SHIFT  = 13;
  localparam int PROD_W       = SUM_W + RECIP_W;

  localparam int DEF_MAX_WIDTH = 1024;

  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = WIDTH_REG_W'(1024);
  localparam logic [HEIGHT_W-1:0]    HEIGHT_RESET = HEIGHT_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 1'b0,
    CFG_HEIGHT = 1'b1
  } cfg_idx_t;

  // Scaled reciprocal of the divisor; the quotient is (sum * recip) >> 13.
  // The error stays below one unit for sums up to five full-scale pixels.
  function automatic logic [RECIP_W-1:0] recip(input logic [DIV_W-1:0] n);
    logic [RECIP_W-1:0] r;
    case (n)
      3'd2:    r = RECIP_W'(4096);
      3'd3:    r = RECIP_W'(2731);
      3'd4:    r = RECIP_W'(2048);
      3'd5:    r = RECIP_W'(1639);
      default: r = RECIP_W'(8192);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/fnmb_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fnmb_in_if
// Pixel input channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fnmb_in_if import fnmb_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             drain;

  modport source (output valid, output pixel, output drain, input ready);
  modport sink   (input valid, input pixel, input drain, output ready);
endinterface
`default_nettype wire

[sv/fnmb_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fnmb_out_if
// Filtered pixel output channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fnmb_out_if import fnmb_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blurred;
  logic             last_of_frame;

  modport source (output valid, output blurred, output last_of_frame, input ready);
  modport sink   (input valid, input blurred, input last_of_frame, output ready);
endinterface
`default_nettype wire

[sv/fnmb_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fnmb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fnmb_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[sv/four_neighbour_mean_blur.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// four_neighbour_mean_blur
// Five-point cross mean filter over a raster-order 8-bit image plane.
// ----------------------------------------------------------------------------
// Throughput: one transaction per clock while the output is not stalled; each
//   line memory does one read and one write per pixel, and that single read
//   port per memory sets the rate. A result's completing input passes the
//   accept (memory read), data (sum) and divide (reciprocal multiply) stages.
// Reset (synchronous, rst_n low): counters clear, width and height return to
//   1024, the pipeline empties. The line memories are not cleared.
// ----------------------------------------------------------------------------
module four_neighbour_mean_blur import fnmb_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fnmb_in_if.sink               in_pix,
  fnmb_out_if.source            out_pix,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Column address width and a compare width that holds both the width
  // register and MAX_WIDTH itself.
  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;

  // Item travelling from the accept stage to the memory data stage.
  typedef struct packed {
    logic [AW-1:0]    pos;       // column of the centre pixel
    logic [PIX_W-1:0] px;        // incoming pixel (the lower neighbour)
    logic             wr_mid;    // pixel item: store px in the middle line
    logic             wr_up;     // move the old middle entry to the upper line
    logic             produce;   // a result leaves for this item
    logic             up_en;
    logic             left_en;
    logic             right_en;
    logic             down_en;
    logic             last;
    logic             fwd_mid;   // middle read hits the write of the item ahead
    logic             fwd_up;    // upper read hits the write of the item ahead
    logic             self_mid;  // lookahead address is this item's own column
    logic [PIX_W-1:0] fwd_mid_d;
    logic [PIX_W-1:0] fwd_up_d;
  } s1_t;

  // --------------------------------------------------------------------------
  // Configuration registers and frame counters
  // --------------------------------------------------------------------------
  logic [WIDTH_REG_W-1:0] width_r;
  logic [HEIGHT_W-1:0]    height_r;
  logic [AW-1:0]          col_r, col_nxt;
  logic [HEIGHT_W-1:0]    row_r, row_nxt;
  logic [AW-1:0]          drn_r, drn_nxt;

  // Effective sizes: a zero width or height acts as one, and a width above
  // the line memory depth is clamped to it.
  logic [CMPW-1:0]     w_eff;
  logic [HEIGHT_W-1:0] h_eff;

  always_comb begin
    if (width_r == '0) begin
      w_eff = CMPW'(1);
    end else if (CMPW'(width_r) > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = CMPW'(width_r);
    end
    h_eff = (height_r == '0) ? HEIGHT_W'(1) : height_r;
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake. Each stage moves when the stage after it has room,
  // so a result waiting at the output blocks new input once the stages fill.
  // --------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, out_v_r;
  logic en_out, en2, en1, accept;

  assign en_out       = !out_v_r || out_pix.ready;
  assign en2          = !s2_v_r || en_out;
  assign en1          = !s1_v_r || en2;
  assign in_pix.ready = en1;
  assign accept       = in_pix.valid && en1;

  // --------------------------------------------------------------------------
  // Accept stage: classify the transaction, step the counters and issue the
  // line memory reads. The middle line is read one column ahead; that value
  // is the right neighbour now and the centre of the next item.
  // --------------------------------------------------------------------------
  logic            restart;
  logic [AW-1:0]   c0, d0, pos, nxt_addr;
  logic [HEIGHT_W-1:0] r0;
  logic [CMPW-1:0] pos_inc;
  logic            pos_wrap;
  logic            pix_eff, drn_eff, item_eff;
  s1_t             s1_r, s1_nxt;

  logic [PIX_W-1:0] cen_r;    // middle line entry at the next item's column
  logic [PIX_W-1:0] lft_r;    // centre of the previous item
  logic [PIX_W-1:0] up_rd, mid_rd;

  always_comb begin
    // Counters outside their range restart the frame; this cannot arise
    // when configuration writes clear them, but keeps the block self-healing.
    restart = (CMPW'(col_r) >= w_eff) || (CMPW'(drn_r) >= w_eff) || (row_r > h_eff);
    c0 = restart ? '0 : col_r;
    d0 = restart ? '0 : drn_r;
    r0 = restart ? '0 : row_r;

    // A pixel counts until all rows are in; a drain counts only after that.
    pix_eff  = !in_pix.drain && (r0 < h_eff);
    drn_eff  = in_pix.drain && (r0 >= h_eff);
    item_eff = accept && (pix_eff || drn_eff);

    pos      = in_pix.drain ? d0 : c0;
    pos_inc  = CMPW'(pos) + CMPW'(1);
    pos_wrap = (pos_inc == w_eff);
    nxt_addr = pos_wrap ? '0 : pos_inc[AW-1:0];

    s1_nxt.pos       = pos;
    s1_nxt.px        = in_pix.pixel;
    s1_nxt.wr_mid    = !in_pix.drain;
    s1_nxt.wr_up     = !in_pix.drain && (r0 != '0);
    s1_nxt.produce   = in_pix.drain || (r0 != '0);
    s1_nxt.up_en     = in_pix.drain ? (h_eff > HEIGHT_W'(1)) : (r0 >= HEIGHT_W'(2));
    s1_nxt.left_en   = (pos != '0);
    s1_nxt.right_en  = !pos_wrap;
    s1_nxt.down_en   = !in_pix.drain;
    s1_nxt.last      = in_pix.drain && pos_wrap;
    s1_nxt.fwd_mid   = s1_v_r && s1_r.wr_mid && (s1_r.pos == nxt_addr);
    s1_nxt.fwd_up    = s1_v_r && s1_r.wr_up && (s1_r.pos == pos);
    s1_nxt.self_mid  = !in_pix.drain && (nxt_addr == pos);
    s1_nxt.fwd_mid_d = s1_r.px;
    s1_nxt.fwd_up_d  = cen_r;

    // Counter stepping.
    col_nxt = col_r;
    row_nxt = row_r;
    drn_nxt = drn_r;
    if (accept) begin
      col_nxt = c0;
      row_nxt = r0;
      drn_nxt = d0;
      if (pix_eff) begin
        if (pos_wrap) begin
          col_nxt = '0;
          row_nxt = r0 + HEIGHT_W'(1);
        end else begin
          col_nxt = pos_inc[AW-1:0];
        end
      end else if (drn_eff) begin
        if (pos_wrap) begin
          col_nxt = '0;
          row_nxt = '0;
          drn_nxt = '0;
        end else begin
          drn_nxt = pos_inc[AW-1:0];
        end
      end
    end
    // Any register write restarts the frame.
    if (cfg_we) begin
      col_nxt = '0;
      row_nxt = '0;
      drn_nxt = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Line memories. Reads are issued at acceptance, writes happen when the
  // item leaves the data stage. A read that meets a write of the item one
  // stage ahead takes its data through the forward fields above.
  // --------------------------------------------------------------------------
  logic s1_go;
  assign s1_go = s1_v_r && en2;

  fnmb_ram #(.W(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (s1_go && s1_r.wr_up),
    .waddr (s1_r.pos),
    .wdata (cen_r),
    .re    (item_eff),
    .raddr (pos),
    .rdata (up_rd)
  );

  fnmb_ram #(.W(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (s1_go && s1_r.wr_mid),
    .waddr (s1_r.pos),
    .wdata (s1_r.px),
    .re    (item_eff),
    .raddr (nxt_addr),
    .rdata (mid_rd)
  );

  // --------------------------------------------------------------------------
  // Data stage: gather the in-bounds neighbours and count them.
  //   centre = cen_r, left = lft_r, up = upper read, right = lookahead read,
  //   down = the incoming pixel (pixel items only).
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] up_val, right_val;
  logic [SUM_W-1:0] sum_nxt;
  logic [DIV_W-1:0] n_nxt;

  always_comb begin
    up_val = s1_r.fwd_up ? s1_r.fwd_up_d : up_rd;
    if (s1_r.self_mid) begin
      right_val = s1_r.px;
    end else if (s1_r.fwd_mid) begin
      right_val = s1_r.fwd_mid_d;
    end else begin
      right_val = mid_rd;
    end
    sum_nxt = SUM_W'(cen_r)
            + (s1_r.up_en    ? SUM_W'(up_val)    : '0)
            + (s1_r.left_en  ? SUM_W'(lft_r)     : '0)
            + (s1_r.right_en ? SUM_W'(right_val) : '0)
            + (s1_r.down_en  ? SUM_W'(s1_r.px)   : '0);
    n_nxt = DIV_W'(1) + DIV_W'(s1_r.up_en) + DIV_W'(s1_r.left_en)
          + DIV_W'(s1_r.right_en) + DIV_W'(s1_r.down_en);
  end

  // --------------------------------------------------------------------------
  // Divide stage: multiply by the scaled reciprocal of the neighbour count.
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0]  s2_sum_r;
  logic [DIV_W-1:0]  s2_n_r;
  logic              s2_last_r;
  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(s2_sum_r) * PROD_W'(recip(s2_n_r));

  logic [PIX_W-1:0] out_px_r;
  logic             out_last_r;

  assign out_pix.valid         = out_v_r;
  assign out_pix.blurred       = out_px_r;
  assign out_pix.last_of_frame = out_last_r;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      col_r    <= '0;
      row_r    <= '0;
      drn_r    <= '0;
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      drn_r <= drn_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_idx))
          CFG_WIDTH:  width_r  <= cfg_wdata[WIDTH_REG_W-1:0];
          CFG_HEIGHT: height_r <= cfg_wdata[HEIGHT_W-1:0];
        endcase
      end
      if (en1) begin
        s1_v_r <= item_eff;
      end
      if (en2) begin
        s2_v_r <= s1_v_r && s1_r.produce;
      end
      if (en_out) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_eff) begin
      s1_r <= s1_nxt;
    end
    if (s1_go) begin
      // The lookahead read becomes the next centre; this centre the next left.
      cen_r     <= right_val;
      lft_r     <= cen_r;
      s2_sum_r  <= sum_nxt;
      s2_n_r    <= n_nxt;
      s2_last_r <= s1_r.last;
    end
    if (en_out && s2_v_r) begin
      out_px_r   <= prod[RECIP_SHIFT +: PIX_W];
      out_last_r <= s2_last_r;
    end
  end

endmodule
`default_nettype wire
